[rtl/core/teb_pkg.sv]
// teb_pkg: types, constants and the cosine table builder for the emergency brake.
// Used by teb_ctrl, teb_dp, ttc_emergency_brake, teb_brake_checker and the testbench. No dependencies.

package teb_pkg;

  // Stream layout
  localparam int S_TDATA_W  = 32;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 8;
  localparam int SPEED_LSB  = 0;
  localparam int RANGE_LSB  = 16;
  localparam int TUSER_COMMAND = 0;
  localparam int TUSER_VALID   = 1;

  // Field widths
  localparam int SPEED_W = 16;
  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 32;

  // Command codes (tuser bit 0)
  localparam logic CMD_SPEED = 1'b0;
  localparam logic CMD_BEAM  = 1'b1;

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam int THR_W      = 16;
  localparam int START_W    = 19;
  localparam int STEP_W     = 16;
  localparam int MINC_W     = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TTC_THRESHOLD,
    REG_ANGLE_START,
    REG_ANGLE_STEP,
    REG_MIN_CLOSING
  } cfg_reg_t;

  localparam logic [THR_W-1:0]          RST_TTC_THRESHOLD = 16'd300;
  localparam logic signed [START_W-1:0] RST_ANGLE_START   = -19'sd154415;
  localparam logic [STEP_W-1:0]         RST_ANGLE_STEP    = 16'd286;
  localparam logic [MINC_W-1:0]         RST_MIN_CLOSING   = 10'd1;

  // Angle and cosine table
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int COS_FRAC_BITS   = 15;
  localparam int HALF_PI_UNITS   = 102944;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int MS_PER_S        = 1000;

  localparam int COS_W = COS_FRAC_BITS + 1;
  localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1);
  localparam int MAG_W = $clog2(HALF_PI_UNITS);

  // Rounded index: (mag*DEPTH + D/2) / D, done by reciprocal plus one correction
  localparam longint NUM_MAX =
    longint'(HALF_PI_UNITS - 1) * COS_TABLE_DEPTH + HALF_PI_UNITS / 2;
  localparam int NUM_W = $clog2(NUM_MAX + 1);
  localparam longint unsigned RECIP = (64'd1 << NUM_W) / HALF_PI_UNITS;
  localparam int RCP_W = $clog2(RECIP + 1);
  localparam int P1_W  = NUM_W + RCP_W;

  // Closing rate and TTC compare
  localparam int CLOSE_W = (SPEED_W - 1) + COS_W;
  localparam int RHS_W   = THR_W + CLOSE_W;
  localparam int LHS_W   = RANGE_W + 10 + COS_FRAC_BITS;
  localparam int CMP_W   = (RHS_W > LHS_W) ? RHS_W : LHS_W;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDX_MUL,
    ST_IDX_FIX,
    ST_ROM_RD,
    ST_CLOSE_MUL,
    ST_TTC_MUL,
    ST_RESULT
  } teb_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic idx_mul;
    logic idx_fix;
    logic rom_rd;
    logic close_mul;
    logic ttc_mul;
    logic finish;
  } teb_cmd_t;

  // Taylor divisors (2n-1)*2n for n = 1..14
  localparam longint unsigned TAYLOR_DIV [1:14] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
    64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
  };

  typedef logic [COS_W-1:0] cos_rom_t [COS_TABLE_DEPTH+1];

  // One table entry: cos(k*(pi/2)/DEPTH) in Q30 by series, rounded to COS_FRAC_BITS
  function automatic logic [COS_W-1:0] cos_entry(input longint unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      r;
    x    = (k * HALF_PI_Q30) / COS_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int n = 1; n <= 14; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      return '0;
    end
    r = (sum + (longint'(1) << (29 - COS_FRAC_BITS))) >>> (30 - COS_FRAC_BITS);
    if (r > (longint'(1) << COS_FRAC_BITS)) begin
      r = longint'(1) << COS_FRAC_BITS;
    end
    return r[COS_W-1:0];
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
      rom[k] = cos_entry(longint'(k));
    end
    return rom;
  endfunction

endpackage

[rtl/core/teb_ctrl.sv]
// teb_ctrl: sequencer for the emergency brake; steps one item through the datapath.
// Depends on teb_pkg (state enum, command struct).

module teb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              item_is_beam,
  input  logic              out_free,
  output logic              in_ready,
  output teb_pkg::teb_cmd_t cmd
);
  import teb_pkg::*;

  teb_state_t state;
  teb_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = (item_is_beam == CMD_BEAM) ? ST_IDX_MUL : ST_RESULT;
        end
      end
      ST_IDX_MUL: begin
        cmd.idx_mul = 1'b1;
        state_next  = ST_IDX_FIX;
      end
      ST_IDX_FIX: begin
        cmd.idx_fix = 1'b1;
        state_next  = ST_ROM_RD;
      end
      ST_ROM_RD: begin
        cmd.rom_rd = 1'b1;
        state_next = ST_CLOSE_MUL;
      end
      ST_CLOSE_MUL: begin
        cmd.close_mul = 1'b1;
        state_next    = ST_TTC_MUL;
      end
      ST_TTC_MUL: begin
        cmd.ttc_mul = 1'b1;
        state_next  = ST_RESULT;
      end
      ST_RESULT: begin
        // hold until the output register can take the beat
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_finish_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> out_free)
    else $error("result loaded while output register busy");

  a_beam_starts_index: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && item_is_beam == CMD_BEAM) |=> cmd.idx_mul)
    else $error("beam accepted but index step did not follow");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.idx_mul, cmd.idx_fix, cmd.rom_rd,
              cmd.close_mul, cmd.ttc_mul, cmd.finish}))
    else $error("more than one datapath command at once");
`endif

endmodule

[rtl/core/teb_dp.sv]
// teb_dp: datapath of the emergency brake: config registers, speed and angle state,
// index divider, cosine ROM, closing-rate and TTC multipliers, output register.
// Depends on teb_pkg.

module teb_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  teb_pkg::teb_cmd_t               cmd,
  input  logic [teb_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [teb_pkg::S_TUSER_W-1:0]   s_tuser,
  input  logic                            s_tlast,
  input  logic                            cfg_we,
  input  logic [teb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [teb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_free,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [teb_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                            m_tlast
);
  import teb_pkg::*;

  localparam cos_rom_t COS_ROM = build_cos_rom();

  // Configuration
  logic [THR_W-1:0]          thr;
  logic signed [START_W-1:0] start;
  logic [STEP_W-1:0]         step;
  logic [MINC_W-1:0]         minc;

  // Persistent state
  logic signed [SPEED_W-1:0] cur_speed;
  logic [ANGLE_W-1:0]        beam_angle;
  logic                      brake_sent;

  // Item registers
  logic                is_beam_q;
  logic                last_q;
  logic                qual_q;
  logic [RANGE_W-1:0]  range_q;
  logic [MAG_W-1:0]    mag_q;
  logic [IDX_W-1:0]    qest_q;
  logic [IDX_W-1:0]    idx_q;
  logic [COS_W-1:0]    cos_q;
  logic [CLOSE_W-1:0]  closing_q;
  logic                above_min_q;
  logic [CMP_W-1:0]    lhs_q;
  logic [CMP_W-1:0]    rhs_q;
  logic                brake_q;
  logic                scan_end_q;

  // Combinational
  logic                 accept_beam;
  logic [ANGLE_W-1:0]   mag_full;
  logic                 in_range;
  logic [ANGLE_W-1:0]   start_ext;
  logic [NUM_W-1:0]     num;
  logic [P1_W-1:0]      prod1;
  logic [NUM_W-1:0]     rem;
  logic [IDX_W-1:0]     idx_raw;
  logic                 trig;

  assign accept_beam = cmd.accept && (s_tuser[TUSER_COMMAND] == CMD_BEAM);
  assign start_ext   = {{(ANGLE_W - START_W){start[START_W-1]}}, start};

  // |angle| and half-pi window
  assign mag_full = beam_angle[ANGLE_W-1] ? (~beam_angle + 1'b1) : beam_angle;
  assign in_range = mag_full < ANGLE_W'(HALF_PI_UNITS);

  // Rounded table index: reciprocal estimate then one correction
  assign num   = NUM_W'(mag_q) * NUM_W'(COS_TABLE_DEPTH) + NUM_W'(HALF_PI_UNITS / 2);
  assign prod1 = P1_W'(num) * P1_W'(RECIP);
  assign rem   = num - NUM_W'(qest_q) * NUM_W'(HALF_PI_UNITS);
  assign idx_raw = qest_q + IDX_W'(rem >= NUM_W'(HALF_PI_UNITS));

  assign trig = is_beam_q && qual_q && above_min_q && (lhs_q <= rhs_q);

  // Config registers, speed, angle accumulator, brake-once flag
  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= RST_TTC_THRESHOLD;
      start      <= RST_ANGLE_START;
      step       <= RST_ANGLE_STEP;
      minc       <= RST_MIN_CLOSING;
      cur_speed  <= '0;
      beam_angle <= {{(ANGLE_W - START_W){RST_ANGLE_START[START_W-1]}}, RST_ANGLE_START};
      brake_sent <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TTC_THRESHOLD: thr  <= cfg_data[THR_W-1:0];
          REG_ANGLE_START: begin
            start      <= cfg_data[START_W-1:0];
            beam_angle <= {{(ANGLE_W - START_W){cfg_data[START_W-1]}}, cfg_data[START_W-1:0]};
          end
          REG_ANGLE_STEP:    step <= cfg_data[STEP_W-1:0];
          REG_MIN_CLOSING:   minc <= cfg_data[MINC_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept && (s_tuser[TUSER_COMMAND] == CMD_SPEED)) begin
        cur_speed <= s_tdata[SPEED_LSB +: SPEED_W];
      end
      // angle is sampled at accept, so the accumulator moves on right away
      if (accept_beam) begin
        beam_angle <= s_tlast ? start_ext : beam_angle + ANGLE_W'(step);
      end
      if (cmd.finish && is_beam_q) begin
        if (last_q) begin
          brake_sent <= 1'b0;
        end else if (trig) begin
          brake_sent <= 1'b1;
        end
      end
    end
  end

  // Item pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_beam_q <= (s_tuser[TUSER_COMMAND] == CMD_BEAM);
      last_q    <= s_tlast;
      range_q   <= s_tdata[RANGE_LSB +: RANGE_W];
      mag_q     <= mag_full[MAG_W-1:0];
      qual_q    <= (s_tuser[TUSER_COMMAND] == CMD_BEAM) && s_tuser[TUSER_VALID] &&
                   !brake_sent && in_range &&
                   !cur_speed[SPEED_W-1] && (cur_speed != '0);
    end
    if (cmd.idx_mul) begin
      qest_q <= prod1[NUM_W +: IDX_W];
    end
    if (cmd.idx_fix) begin
      idx_q <= (idx_raw > IDX_W'(COS_TABLE_DEPTH)) ? IDX_W'(COS_TABLE_DEPTH) : idx_raw;
    end
    // cosine ROM, registered read
    if (cmd.rom_rd) begin
      cos_q <= COS_ROM[idx_q];
    end
    if (cmd.close_mul) begin
      closing_q <= CLOSE_W'(cur_speed[SPEED_W-2:0]) * CLOSE_W'(cos_q);
    end
    // range*1000 << frac  vs  threshold*closing
    if (cmd.ttc_mul) begin
      lhs_q       <= (CMP_W'(range_q) * CMP_W'(MS_PER_S)) << COS_FRAC_BITS;
      rhs_q       <= CMP_W'(thr) * CMP_W'(closing_q);
      above_min_q <= closing_q > (CLOSE_W'(minc) << COS_FRAC_BITS);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      brake_q    <= trig;
      scan_end_q <= is_beam_q && last_q;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {{(M_TDATA_W - 1){1'b0}}, brake_q};
  assign m_tlast  = scan_end_q;

`ifndef SYNTHESIS
  a_finish_shows_beat: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("finished result not presented");

  a_index_in_table: assert property (@(posedge clk) disable iff (rst)
    cmd.idx_fix |=> (idx_q <= IDX_W'(COS_TABLE_DEPTH)))
    else $error("cosine index beyond table");

  a_brake_once: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && trig) |-> !brake_sent)
    else $error("second brake in one scan");
`endif

endmodule

[rtl/core/ttc_emergency_brake.sv]
// ttc_emergency_brake: top level of the time-to-collision emergency brake.
// Depends on teb_pkg, teb_ctrl, teb_dp.
//
//  channel  | direction | fields
//  s_*      | in        | tdata: speed_mm_s[15:0], range_mm[31:16]; tuser: command, range_valid;
//           |           | tlast: last_beam
//  m_*      | out       | tdata: brake[0], zero pad; tlast: scan_end
//  cfg_*    | in        | cfg_index: register number, cfg_data: value, cfg_we: write strobe
//
// A beam is accepted, then the sequencer walks the index multiply, index correction,
// cosine ROM read, closing-rate multiply and TTC multiply in turn before its result
// step; a speed update goes straight from accept to the result step. One item is in
// flight at a time; s_tready is high only while idle. A finished beat waits in the
// output register, so a stalled m_tready holds the sequencer in its result step.
// Reset is synchronous and loads the register defaults; there is no clearing pass.

module ttc_emergency_brake (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [teb_pkg::S_TDATA_W-1:0]   s_tdata,   // speed_mm_s[15:0], range_mm[31:16]
  input  logic [teb_pkg::S_TUSER_W-1:0]   s_tuser,   // command[0], range_valid[1]
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [teb_pkg::M_TDATA_W-1:0]   m_tdata,   // brake[0], zeros[7:1]
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [teb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [teb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import teb_pkg::*;

  teb_cmd_t cmd;
  logic     out_free;

  // Sequencer
  teb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .item_is_beam (s_tuser[TUSER_COMMAND]),
    .out_free     (out_free),
    .in_ready     (s_tready),
    .cmd          (cmd)
  );

  // Datapath
  teb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

[dv/teb_brake_checker.sv]
// teb_brake_checker: watches the stream and config ports of ttc_emergency_brake, predicts
// brake and scan_end for every accepted beat and compares them with the result beats.
// Depends on teb_pkg for widths, register names and fixed-point constants.

module teb_brake_checker
  import teb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // speed_mm_s[15:0], range_mm[31:16]
  input  logic [S_TUSER_W-1:0]  s_tuser,   // command[0], range_valid[1]
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,   // brake[0], zeros[7:1]
  input  logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic brake;
    logic scan_end;
  } verdict_t;

  verdict_t brake_due[$];

  // Quarter-wave cosine, Q1.15
  int unsigned cos_q15 [0:COS_TABLE_DEPTH];

  // Register copies
  logic [THR_W-1:0]          thr_ms;
  logic signed [START_W-1:0] start_ang;
  logic [STEP_W-1:0]         step_ang;
  logic [MINC_W-1:0]         min_close;

  // Block state
  logic signed [SPEED_W-1:0] speed;
  logic [ANGLE_W-1:0]        angle;
  logic                      braked;

  // cos(k * (pi/2) / DEPTH): Taylor series in Q30, rounded to Q15 and clamped
  function automatic int unsigned cos_sample(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned div;
    longint          acc;
    int unsigned     res;
    x    = (longint'(k) * HALF_PI_Q30) / COS_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    acc  = longint'(term);
    for (int n = 1; n <= 14; n++) begin
      div  = (2 * n - 1) * (2 * n);
      term = ((term * x2) >> 30) / div;
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      return 0;
    end
    acc = (acc + (longint'(1) <<< (29 - COS_FRAC_BITS))) >>> (30 - COS_FRAC_BITS);
    if (acc > (longint'(1) <<< COS_FRAC_BITS)) begin
      acc = longint'(1) <<< COS_FRAC_BITS;
    end
    res = acc[31:0];
    return res;
  endfunction

  function automatic logic [ANGLE_W-1:0] start_angle();
    return {{(ANGLE_W - START_W){start_ang[START_W-1]}}, start_ang};
  endfunction

  // Apply one input beat to the state copy and return the result it causes
  function automatic verdict_t predict_brake(input logic cmd,
                                             input logic [SPEED_W-1:0] spd,
                                             input logic [RANGE_W-1:0] rng,
                                             input logic vld,
                                             input logic lst);
    verdict_t        v;
    longint          a;
    longint          mag;
    longint unsigned idx;
    longint unsigned closing;
    longint unsigned lhs;
    longint unsigned rhs;
    v = '0;
    if (cmd == CMD_SPEED) begin
      speed = spd;
    end else begin
      a   = longint'($signed(angle));
      mag = (a < 0) ? -a : a;
      if (!braked && vld && speed > 0 && mag < HALF_PI_UNITS) begin
        idx = (mag * COS_TABLE_DEPTH + HALF_PI_UNITS / 2) / HALF_PI_UNITS;
        if (idx > COS_TABLE_DEPTH) begin
          idx = COS_TABLE_DEPTH;
        end
        closing = longint'(speed) * cos_q15[idx];
        lhs     = (longint'(rng) * MS_PER_S) << COS_FRAC_BITS;
        rhs     = longint'(thr_ms) * closing;
        if (closing > (longint'(min_close) << COS_FRAC_BITS) && lhs <= rhs) begin
          v.brake = 1'b1;
          braked  = 1'b1;
        end
      end
      // accumulator moves on every beam, skipped or not
      angle = angle + ANGLE_W'(step_ang);
      if (lst) begin
        v.scan_end = 1'b1;
        angle      = start_angle();
        braked     = 1'b0;
      end
    end
    return v;
  endfunction

  initial begin
    for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
      cos_q15[k] = cos_sample(k);
    end
  end

  // Track config, predict on input beats, compare on output beats
  always @(posedge clk) begin : watch
    verdict_t due;
    if (rst) begin
      thr_ms    = RST_TTC_THRESHOLD;
      start_ang = RST_ANGLE_START;
      step_ang  = RST_ANGLE_STEP;
      min_close = RST_MIN_CLOSING;
      speed     = '0;
      angle     = start_angle();
      braked    = 1'b0;
      brake_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TTC_THRESHOLD: thr_ms = cfg_data[THR_W-1:0];
          REG_ANGLE_START: begin
            start_ang = cfg_data[START_W-1:0];
            angle     = start_angle();
          end
          REG_ANGLE_STEP:    step_ang = cfg_data[STEP_W-1:0];
          REG_MIN_CLOSING:   min_close = cfg_data[MINC_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        brake_due.push_back(predict_brake(s_tuser[TUSER_COMMAND],
                                          s_tdata[SPEED_LSB +: SPEED_W],
                                          s_tdata[RANGE_LSB +: RANGE_W],
                                          s_tuser[TUSER_VALID], s_tlast));
      end
      if (m_tvalid && m_tready) begin
        if (brake_due.size() == 0) begin
          $error("result beat with nothing predicted: brake %0b, scan_end %0b",
                 m_tdata[0], m_tlast);
          mismatches++;
        end else begin
          due = brake_due.pop_front();
          if (due.brake !== m_tdata[0]) begin
            $error("brake: expected %0b, got %0b", due.brake, m_tdata[0]);
            mismatches++;
          end
          if (due.scan_end !== m_tlast) begin
            $error("scan_end: expected %0b, got %0b", due.scan_end, m_tlast);
            mismatches++;
          end
        end
      end
    end
    outstanding <= brake_due.size();
  end

endmodule

[dv/tb_ttc_emergency_brake.sv]
// tb_ttc_emergency_brake: stimulus and verdict for ttc_emergency_brake.
// Drives directed, random and wide-step sweep beats; teb_brake_checker does the checking.
// Depends on teb_pkg, ttc_emergency_brake and teb_brake_checker.

module tb_ttc_emergency_brake;
  import teb_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int HOLD_AT       = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_BEATS   = 200;
  localparam int SWEEP_BEAMS   = 64;

  typedef struct {
    logic               cmd;
    logic [SPEED_W-1:0] speed;
    logic [RANGE_W-1:0] range;
    logic               valid;
    logic               last;
  } beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // speed_mm_s[15:0], range_mm[31:16]
  logic [S_TUSER_W-1:0]  s_tuser = '0;   // command[0], range_valid[1]
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // brake[0], zeros[7:1]
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    outstanding;

  int unsigned cycle_count = 0;
  int          beats_sent = 0;
  bit          send_calm = 1'b0;
  bit          rush = 1'b0;       // no idling on either side
  int          cur_speed = 0;
  int          cur_thr = RST_TTC_THRESHOLD;

  ttc_emergency_brake uut (.*);
  teb_brake_checker chk (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, calm stretches and one long hold-off
  initial begin : receiver
    int gap;
    int taken;
    bit take_calm;
    taken     = 0;
    take_calm = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 50 == 0) take_calm = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT) begin
        gap = HOLD_CYCLES;
      end else begin
        gap = (rush || take_calm) ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  // Offer one beat after a random gap; valid stays high between back-to-back beats
  task automatic send_beat(input beat_t b);
    int                   gap;
    logic [S_TDATA_W-1:0] word;
    logic [S_TUSER_W-1:0] kind;
    if (beats_sent % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap  = (rush || send_calm) ? 0 : $urandom_range(0, 15);
    word = '0;
    word[SPEED_LSB +: SPEED_W] = b.speed;
    word[RANGE_LSB +: RANGE_W] = b.range;
    kind = '0;
    kind[TUSER_COMMAND] = b.cmd;
    kind[TUSER_VALID]   = b.valid;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= kind;
    s_tlast  <= b.last;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  // Speed update; range, valid and last carry noise the block must ignore
  function automatic beat_t speed_beat(input int spd);
    beat_t b;
    b.cmd   = CMD_SPEED;
    b.speed = spd[SPEED_W-1:0];
    b.range = RANGE_W'($urandom);
    b.valid = 1'($urandom);
    b.last  = 1'($urandom);
    return b;
  endfunction

  function automatic beat_t lidar_beat(input int rng, input bit vld, input bit lst);
    beat_t b;
    b.cmd   = CMD_BEAM;
    b.speed = SPEED_W'($urandom);
    b.range = rng[RANGE_W-1:0];
    b.valid = vld;
    b.last  = lst;
    return b;
  endfunction

  task automatic send_speed(input int spd);
    cur_speed = spd;
    send_beat(speed_beat(spd));
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int thr, input int start, input int step, input int minc);
    wait_idle();
    write_reg(REG_TTC_THRESHOLD, thr);
    write_reg(REG_ANGLE_START, start);
    write_reg(REG_ANGLE_STEP, step);
    write_reg(REG_MIN_CLOSING, minc);
    cur_thr = thr;
  endtask

  // Scans of random length with random content, plus speed updates and stray beams
  task automatic random_phase(input int count);
    int     left;
    int     pick;
    int     spd;
    int     rng;
    longint bnd;
    left = $urandom_range(0, 40);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        case ($urandom_range(0, 3))
          0:       spd = int'($urandom_range(0, 65535)) - 32768;
          1:       spd = $urandom_range(0, 2000);
          default: spd = $urandom_range(1, 32767);
        endcase
        send_speed(spd);
      end else if (pick < 17) begin
        send_beat(lidar_beat($urandom_range(0, 65535), 1'($urandom), 1'($urandom)));
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            // near the time-to-collision boundary for a beam straight ahead
            bnd = (longint'(cur_thr) * ((cur_speed > 0) ? cur_speed : 0)) / 1000;
            bnd = bnd + $urandom_range(0, 64) - 32;
            if (bnd < 0) bnd = 0;
            if (bnd > 65535) bnd = 65535;
            rng = int'(bnd);
          end
          1:       rng = $urandom_range(0, 4095);
          default: rng = $urandom_range(0, 65535);
        endcase
        send_beat(lidar_beat(rng, $urandom_range(0, 9) != 0, left == 0));
        if (left == 0) begin
          left = $urandom_range(0, 40);
        end else begin
          left--;
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero speed, then beams far off to the side
    send_beat(lidar_beat(0, 1'b1, 1'b0));
    send_speed(32767);
    send_beat(lidar_beat(0, 1'b1, 1'b0));
    send_beat(lidar_beat(0, 1'b1, 1'b1));

    // Straight ahead, widest threshold
    set_config(65535, 0, 0, 0);
    send_beat(lidar_beat(0, 1'b0, 1'b0));      // no object
    send_beat(lidar_beat(0, 1'b1, 1'b0));      // brakes
    send_beat(lidar_beat(0, 1'b1, 1'b0));      // already braked this scan
    send_beat(lidar_beat(65535, 1'b1, 1'b1));
    send_beat(lidar_beat(65535, 1'b1, 1'b1));  // fresh scan, far object
    send_speed(-32768);
    send_beat(lidar_beat(0, 1'b1, 1'b1));
    send_speed(0);
    send_beat(lidar_beat(0, 1'b1, 1'b1));
    send_speed(1);
    send_beat(lidar_beat(0, 1'b1, 1'b1));

    // Widest start and step, zero threshold: beams sweep across the window
    set_config(0, -205887, 65535, 1023);
    send_speed(32767);
    for (int i = 0; i < 5; i++) send_beat(lidar_beat(0, 1'b1, 1'b0));
    send_beat(lidar_beat(1, 1'b1, 1'b1));

    // Minimum closing rate right at the limit
    set_config(300, 0, 0, 1023);
    send_speed(1023);
    send_beat(lidar_beat(0, 1'b1, 1'b1));
    send_speed(1024);
    send_beat(lidar_beat(0, 1'b1, 1'b1));

    // Random scans under several settings; phases often end mid-scan
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_config(65535, -205887, 65535, 0);
        1: set_config(0, 0, 0, 1023);
        2: set_config($urandom_range(0, 65535), int'($urandom_range(0, 411774)) - 205887,
                      $urandom_range(0, 6000), $urandom_range(0, 1023));
        default: set_config($urandom_range(0, 2000), int'($urandom_range(0, 411774)) - 205887,
                            $urandom_range(0, 6000), $urandom_range(0, 63));
      endcase
      random_phase(PHASE_BEATS);
    end

    // One back-to-back scan with the widest step, sweeping through the window and past it
    set_config(65535, -205887, 65535, 0);
    rush = 1'b1;
    send_speed(32767);
    for (int i = 0; i < SWEEP_BEAMS; i++) begin
      send_beat(lidar_beat($urandom_range(0, 2000), 1'b1, i == SWEEP_BEAMS - 1));
    end
    rush = 1'b0;

    wait_idle();
    repeat (12) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/teb_pkg.sv
rtl/core/teb_ctrl.sv
rtl/core/teb_dp.sv
rtl/core/ttc_emergency_brake.sv
dv/teb_brake_checker.sv
dv/tb_ttc_emergency_brake.sv
